[rtl/spr_pkg.sv]
// Shared types, codes and sizes for the stereo pinhole reprojection block.
// No dependencies; every other file but spr_if imports this package.
`default_nettype none
package spr_pkg;

  localparam int QW = 35;          // quotient bits kept before saturation
  localparam int ST = QW;          // one quotient bit per divider stage
  localparam int QDEPTH = 4;       // front-to-back queue depth
  localparam int QAW = 2;

  typedef enum logic [1:0] {
    CMD_PIX2CAM = 2'd0,
    CMD_CAM2PIX = 2'd1,
    CMD_CAM2LR  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_BASELINE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] focal_x;
    logic [31:0] focal_y;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] baseline;
  } cfg_t;

  // numerator = p * m + c * cm, then quotient by c, then + off
  typedef struct packed {
    logic signed [33:0] p;
    logic [31:0]        m;
    logic [31:0]        cm;
    logic [31:0]        off;
  } lane_op_t;

  typedef struct packed {
    logic               zero;
    logic               fault;
    logic signed [31:0] c;
    lane_op_t [2:0]     lane;
  } item_t;

  typedef struct packed {
    logic signed [66:0] pm;
    logic signed [64:0] cc;
    logic [31:0]        off;
  } prod_lane_t;

  typedef struct packed {
    logic               zero;
    logic               fault;
    logic signed [31:0] c;
    prod_lane_t [2:0]   lane;
  } prod_item_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [31:0]   off;
    logic [31:0]   rem;
    logic [QW-1:0] sh;   // low numerator bits shift out, quotient bits shift in
  } div_lane_t;

  typedef struct packed {
    logic            zero;
    logic            fault;
    logic [31:0]     d;
    div_lane_t [2:0] lane;
  } div_item_t;

  function automatic div_lane_t div_step(input div_lane_t x, input logic [31:0] d);
    div_lane_t   r;
    logic [32:0] t;
    logic        ge;
    r  = x;
    t  = {x.rem, x.sh[QW-1]};
    ge = (t >= {1'b0, d});
    r.rem = ge ? 32'(t - {1'b0, d}) : t[31:0];
    r.sh  = {x.sh[QW-2:0], ge};
    return r;
  endfunction

  function automatic logic [31:0] finish(input div_lane_t x);
    logic signed [36:0] v;
    logic signed [37:0] w;
    logic [31:0]        r;
    v = x.neg ? -$signed({2'b00, x.sh}) : $signed({2'b00, x.sh});
    w = $signed({v[36], v}) + $signed({6'b0, x.off});
    if (x.ovf) begin
      r = x.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (w > 38'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (w < -38'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = w[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/spr_if.sv]
// Request channel interfaces: input coordinates and reprojected results.
// Depends on nothing.
`default_nettype none
interface spr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] coord_a;
  logic [31:0] coord_b;
  logic [31:0] coord_c;
  modport source (output valid, cmd, coord_a, coord_b, coord_c, input ready);
  modport sink (input valid, cmd, coord_a, coord_b, coord_c, output ready);
endinterface

interface spr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic        div_fault;
  modport source (output valid, out_a, out_b, out_c, div_fault, input ready);
  modport sink (input valid, out_a, out_b, out_c, div_fault, output ready);
endinterface
`default_nettype wire

[rtl/spr_front.sv]
// Front end: decodes the operation and builds per-lane operands.
// Depends on spr_pkg.
`default_nettype none
module spr_front import spr_pkg::*; (
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] coord_a,
  input  wire logic [31:0] coord_b,
  input  wire logic [31:0] coord_c,
  input  wire cfg_t        cfg,
  output item_t            item
);
  logic signed [33:0] a34, b34, fx34;

  always_comb begin
    a34  = $signed({{2{coord_a[31]}}, coord_a});
    b34  = $signed({{2{coord_b[31]}}, coord_b});
    fx34 = $signed({2'b00, cfg.focal_x});
    item = '0;
    item.c     = $signed(coord_c);
    item.zero  = (cmd == CMD_NONE) || (coord_c == '0);
    item.fault = (cmd != CMD_NONE) && (coord_c == '0);
    unique case (cmd_t'(cmd))
      CMD_PIX2CAM: begin
        item.lane[0].p = a34 - $signed({2'b00, cfg.center_x});
        item.lane[0].m = cfg.baseline;
        item.lane[1].p = b34 - $signed({2'b00, cfg.center_y});
        item.lane[1].m = cfg.baseline;
        item.lane[2].p = fx34;
        item.lane[2].m = cfg.baseline;
      end
      CMD_CAM2PIX: begin
        item.lane[0].p  = a34;
        item.lane[0].m  = cfg.focal_x;
        item.lane[0].cm = cfg.center_x;
        item.lane[1].p  = b34;
        item.lane[1].m  = cfg.focal_y;
        item.lane[1].cm = cfg.center_y;
        item.lane[2].p  = fx34;
        item.lane[2].m  = cfg.baseline;
      end
      CMD_CAM2LR: begin
        item.lane[0].p   = a34;
        item.lane[0].m   = cfg.focal_x;
        item.lane[0].off = cfg.center_x;
        item.lane[1].p   = b34;
        item.lane[1].m   = cfg.focal_y;
        item.lane[1].off = cfg.center_y;
        item.lane[2].p   = a34 - $signed({2'b00, cfg.baseline});
        item.lane[2].m   = cfg.focal_x;
        item.lane[2].off = cfg.center_x;
      end
      CMD_NONE: begin
        item.lane = '0;
      end
      default: item.lane = '0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/spr_queue.sv]
// Short queue of decoded requests between front and back ends.
// Depends on spr_pkg.
`default_nettype none
module spr_queue import spr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wdata,
  input  wire logic  pop,
  output item_t      rdata,
  output logic       full,
  output logic       empty
);
  item_t          mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/spr_back.sv]
// Back end: products, sign handling, pipelined restoring divider, saturation.
// Depends on spr_pkg and spr_if.
`default_nettype none
module spr_back import spr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t q_data,
  input  wire logic  q_empty,
  output logic       q_pop,
  spr_out_if.source  out_ch
);
  logic       en;
  logic       s0_valid, p_valid, o_valid;
  item_t      s0;
  prod_item_t pr;
  logic       dv_valid [ST+1];
  div_item_t  dv [ST+1];
  div_item_t  d0;

  // whole pipe advances together; holds only while the result is refused
  assign en    = !o_valid || out_ch.ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      p_valid  <= 1'b0;
    end else if (en) begin
      s0_valid <= !q_empty;
      p_valid  <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0       <= q_data;
      pr.zero  <= s0.zero;
      pr.fault <= s0.fault;
      pr.c     <= s0.c;
      for (int l = 0; l < 3; l++) begin
        pr.lane[l].pm  <= s0.lane[l].p * $signed({1'b0, s0.lane[l].m});
        pr.lane[l].cc  <= s0.c * $signed({1'b0, s0.lane[l].cm});
        pr.lane[l].off <= s0.lane[l].off;
      end
    end
  end

  // numerator sum, magnitudes, and the top-part overflow test
  always_comb begin
    logic signed [67:0] num;
    logic [66:0]        mag;
    logic [31:0]        hi;
    d0       = '0;
    d0.zero  = pr.zero;
    d0.fault = pr.fault;
    d0.d     = pr.c[31] ? 32'(-pr.c) : pr.c;
    for (int l = 0; l < 3; l++) begin
      num = $signed({pr.lane[l].pm[66], pr.lane[l].pm})
          + $signed({{3{pr.lane[l].cc[64]}}, pr.lane[l].cc});
      mag = num[67] ? 67'(-num) : num[66:0];
      hi  = mag[66:QW];
      d0.lane[l].neg = num[67] ^ pr.c[31];
      d0.lane[l].ovf = (hi >= d0.d);
      d0.lane[l].off = pr.lane[l].off;
      d0.lane[l].rem = (hi >= d0.d) ? '0 : hi;
      d0.lane[l].sh  = mag[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dv[0] <= d0;
  end

  for (genvar s = 1; s <= ST; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s] <= 1'b0;
      end else if (en) begin
        dv_valid[s] <= dv_valid[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s].zero  <= dv[s-1].zero;
        dv[s].fault <= dv[s-1].fault;
        dv[s].d     <= dv[s-1].d;
        for (int l = 0; l < 3; l++) begin
          dv[s].lane[l] <= div_step(dv[s-1].lane[l], dv[s-1].d);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= dv_valid[ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.div_fault <= dv[ST].fault;
      out_ch.out_a <= dv[ST].zero ? '0 : finish(dv[ST].lane[0]);
      out_ch.out_b <= dv[ST].zero ? '0 : finish(dv[ST].lane[1]);
      out_ch.out_c <= dv[ST].zero ? '0 : finish(dv[ST].lane[2]);
    end
  end

  assign out_ch.valid = o_valid;
endmodule
`default_nettype wire

[rtl/stereo_pinhole_reprojection.sv]
// Stereo pinhole reprojection block with its configuration registers.
// Depends on spr_pkg, spr_if, spr_front, spr_queue, spr_back.
//
// Usage: requests arrive on in_ch (valid/ready) carrying cmd and three
// signed Q16.16 coordinates; each gives exactly one result on out_ch
// (out_a, out_b, out_c, div_fault). cmd 0 pixel+disparity to camera,
// cmd 1 camera to pixel+disparity, cmd 2 camera to left/right pixel,
// cmd 3 returns zeros. Zero depth/disparity gives zeros and div_fault.
// Configuration: cfg_we/cfg_index/cfg_data write focal_x, focal_y,
// center_x, center_y, baseline (indexes 0..4); write only while idle.
// Throughput: one request per cycle while out_ch.ready is high. The result
// is registered through the queue, operand and product registers, the
// 35-stage one-bit-per-stage divider and the output registers.
// Reset (rst, synchronous) empties the queue and pipeline and restores
// focal lengths to 1.0, center and baseline to 0.
// When out_ch.ready is low the pipeline holds; the 4-entry queue keeps
// taking requests until full, then in_ch.ready drops.
`default_nettype none
module stereo_pinhole_reprojection import spr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  spr_in_if.sink           in_ch,
  spr_out_if.source        out_ch
);
  cfg_t  cfg;
  item_t f_item, q_data;
  logic  q_full, q_empty, q_pop, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= 32'h0001_0000;
      cfg.focal_y  <= 32'h0001_0000;
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.baseline <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FOCAL_X:  cfg.focal_x  <= cfg_data;
        REG_FOCAL_Y:  cfg.focal_y  <= cfg_data;
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        REG_BASELINE: cfg.baseline <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  spr_front u_front (
    .cmd     (in_ch.cmd),
    .coord_a (in_ch.coord_a),
    .coord_b (in_ch.coord_b),
    .coord_c (in_ch.coord_c),
    .cfg     (cfg),
    .item    (f_item)
  );

  spr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  spr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

[tb/stereo_pinhole_reprojection_tb.sv]
// Testbench for the stereo pinhole reprojection block: directed and random requests,
// checked against an in-bench fixed-point predictor. Depends on spr_pkg and spr_if.
`timescale 1ns / 1ps
module stereo_pinhole_reprojection_tb import spr_pkg::*;;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        fault;
  } proj_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spr_in_if in_ch ();
  spr_out_if out_ch ();

  stereo_pinhole_reprojection dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic [31:0] fx, fy, cx, cy, tx;
  proj_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit send_idle = 1;
  bit recv_idle = 1;
  int recv_hold = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = '0;
    in_ch.coord_a = '0;
    in_ch.coord_b = '0;
    in_ch.coord_c = '0;
    out_ch.ready = 0;
  end

  // Quotient truncated toward zero, magnitude clamped to 2^40.
  function automatic logic signed [63:0] quot(input logic signed [127:0] num,
                                               input logic signed [63:0] den);
    logic [127:0] mn, md, q;
    logic neg;
    neg = num[127] ^ den[63];
    mn = num[127] ? -num : num;
    md = den[63] ? -den : den;
    q = mn / md;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic proj_t reproject(input cmd_t cmd, input logic [31:0] ra,
                                      input logic [31:0] rb, input logic [31:0] rc);
    proj_t r;
    logic signed [127:0] a, b, c, ufx, ufy, ucx, ucy, utx;
    r = '0;
    a = $signed(ra); b = $signed(rb); c = $signed(rc);
    ufx = {96'b0, fx}; ufy = {96'b0, fy}; ucx = {96'b0, cx};
    ucy = {96'b0, cy}; utx = {96'b0, tx};
    if (cmd == CMD_NONE) return r;
    if (c == 0) begin
      r.fault = 1;
      return r;
    end
    case (cmd)
      CMD_PIX2CAM: begin
        r.a = clamp32(quot((a - ucx) * utx, c[63:0]));
        r.b = clamp32(quot((b - ucy) * utx, c[63:0]));
        r.c = clamp32(quot(ufx * utx, c[63:0]));
      end
      CMD_CAM2PIX: begin
        r.a = clamp32(quot(a * ufx + c * ucx, c[63:0]));
        r.b = clamp32(quot(b * ufy + c * ucy, c[63:0]));
        r.c = clamp32(quot(ufx * utx, c[63:0]));
      end
      default: begin
        r.a = clamp32(quot(a * ufx, c[63:0]) + $signed({32'b0, cx}));
        r.b = clamp32(quot(b * ufy, c[63:0]) + $signed({32'b0, cy}));
        r.c = clamp32(quot((a - utx) * ufx, c[63:0]) + $signed({32'b0, cx}));
      end
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker, also drives the receive stalls.
  always @(posedge clk) begin
    proj_t e;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_ch.out_a, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.out_a !== e.a) report("out_a", out_ch.out_a, e.a);
        if (out_ch.out_b !== e.b) report("out_b", out_ch.out_b, e.b);
        if (out_ch.out_c !== e.c) report("out_c", out_ch.out_c, e.c);
        if (out_ch.div_fault !== e.fault) report("div_fault", out_ch.div_fault, e.fault);
      end
    end
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ch.ready <= 0;
    end else if (recv_idle && $urandom_range(0, 19) == 0) begin
      recv_hold <= $urandom_range(1, 14) - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                      input logic [31:0] c);
    int gap;
    if (send_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.coord_a <= a;
    in_ch.coord_b <= b;
    in_ch.coord_c <= c;
    expected_q.insert(expected_q.size(), reproject(cmd, a, b, c));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X: fx = v;
      REG_FOCAL_Y: fy = v;
      REG_CENTER_X: cx = v;
      REG_CENTER_Y: cy = v;
      default: tx = v;
    endcase
  endtask

  task automatic set_camera(input logic [31:0] f1, input logic [31:0] f2,
                            input logic [31:0] c1, input logic [31:0] c2,
                            input logic [31:0] t);
    write_reg(REG_FOCAL_X, f1);
    write_reg(REG_FOCAL_Y, f2);
    write_reg(REG_CENTER_X, c1);
    write_reg(REG_CENTER_Y, c2);
    write_reg(REG_BASELINE, t);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0400_0000)
                                            : -$urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    if ($urandom_range(0, 15) == 0) return 0;
    return rand_coord();
  endfunction

  // Zero divisor, unused code, extremes of every field.
  task automatic test_directed();
    cmd_t ops[4];
    ops = '{CMD_PIX2CAM, CMD_CAM2PIX, CMD_CAM2LR, CMD_NONE};
    set_camera(32'h0100_0000, 32'h00F0_0000, 32'h0140_0000, 32'h00F0_0000, 32'h0000_8000);
    foreach (ops[i]) begin
      send(ops[i], 32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000);
      send(ops[i], 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send(ops[i], 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send(ops[i], 32'h1234_5678, 32'h8765_4321, 32'h0);
      send(ops[i], 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    end
    drain();
  endtask

  // Every register at both extremes, zero baseline included.
  task automatic test_config_extremes();
    set_camera('1, '1, '1, '1, '1);
    repeat (60) send(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_depth());
    drain();
    set_camera('0, '0, '0, '0, '0);
    repeat (60) send(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_depth());
    drain();
  endtask

  task automatic test_random(input int n, input bit idle);
    send_idle = idle;
    recv_idle = idle;
    set_camera($urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
               $urandom(), $urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0010_0000));
    repeat (n) send(cmd_t'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_depth());
    drain();
  endtask

  initial begin
    fx = 32'h0001_0000; fy = 32'h0001_0000; cx = 0; cy = 0; tx = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(CMD_CAM2LR, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000);
    drain();
    test_directed();
    test_config_extremes();
    test_random(300, 1);
    test_random(300, 1);
    test_random(300, 0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spr_pkg.sv
rtl/spr_if.sv
rtl/spr_front.sv
rtl/spr_queue.sv
rtl/spr_back.sv
rtl/stereo_pinhole_reprojection.sv
tb/stereo_pinhole_reprojection_tb.sv
